/* hdl/acp_pkg.sv */
// ----------------------------------------------------------------------------
// acp_pkg
// Shared types and character codes for the ASCII integer parser.
// ----------------------------------------------------------------------------
package acp_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned DIGIT_W = 4;

    // Character codes that steer the parse.
    localparam logic [CHAR_W-1:0] CH_BLANK_MAX = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PLUS      = 8'h2B;  // '+'
    localparam logic [CHAR_W-1:0] CH_MINUS     = 8'h2D;  // '-'
    localparam logic [CHAR_W-1:0] CH_QUOTE     = 8'h27;  // single quote
    localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_NINE      = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CH_LOWER_A   = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CH_LOWER_F   = 8'h66;  // 'f'
    localparam logic [CHAR_W-1:0] CH_UPPER_A   = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CH_UPPER_F   = 8'h46;  // 'F'
    localparam logic [CHAR_W-1:0] CH_LOWER_X   = 8'h78;  // 'x'
    localparam logic [CHAR_W-1:0] CH_UPPER_X   = 8'h58;  // 'X'

    // Letters a-f and A-F carry their digit value as low nibble plus nine.
    localparam logic [DIGIT_W-1:0] HEX_LETTER_OFFSET = 4'd9;

    // Classification of one input byte.
    typedef struct packed {
        logic               blank;
        logic               plus;
        logic               minus;
        logic               zero;
        logic               quote;
        logic               x_letter;
        logic               dec_ok;
        logic               hex_ok;
        logic [DIGIT_W-1:0] digit;
    } t_char_class;

endpackage

/* hdl/ascii_integer_parser.sv */
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Streaming text-to-integer parser with optional sign, hex prefix and quote.
// ----------------------------------------------------------------------------
// The block takes a text field one byte per transfer on the slave stream, with
// tlast on the final byte, and returns one signed 32-bit value per field on
// the master stream, sent for the transfer that carries tlast. Leading bytes
// of code 32 or less are skipped, one '+' or '-' may follow, then "0x"/"0X"
// selects hexadecimal, a quote yields the code of the byte after it, and any
// other body is read as decimal; the first invalid byte freezes the value and
// everything wraps modulo 2^32. One byte is accepted every clock cycle: each
// byte sits in an input register while the parse logic (a constant
// multiply-add on the accumulator) updates the state, and the result of a
// field lands in the output register once its last byte leaves the input
// register. The output register lets new bytes flow while a finished value
// waits; only a last byte whose result cannot be stored holds the input
// side.
module ascii_integer_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream: one byte of text per transfer.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // last_char
    // Master stream: one parsed value per field.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] parsed_value
);

    // Input register.
    logic                         r_in_valid;
    logic [acp_pkg::CHAR_W-1:0]   r_in_char;
    logic                         r_in_last;

    // Output register.
    logic                         r_out_valid;
    logic [acp_pkg::VALUE_W-1:0]  r_out_data;

    logic                          out_free;
    logic                          step_fire;
    acp_pkg::t_char_class          char_class;
    logic signed [acp_pkg::VALUE_W-1:0] step_value;

    // A byte in the input register moves on unless it ends a field and the
    // output register still holds a value nobody has taken.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step_fire     = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || step_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    acp_classify u_classify (
        .i_char  (r_in_char),
        .o_class (char_class)
    );

    acp_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (step_fire),
        .i_last  (r_in_last),
        .i_char  (r_in_char),
        .i_class (char_class),
        .o_value (step_value)
    );

    // The value of a field is captured when its last byte is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire && r_in_last) begin
            r_out_data <= step_value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // An empty input register always takes a byte.
    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input register empty but not ready");

    // Processing a last byte always produces a result on the next cycle.
    a_last_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_fire && r_in_last) |=> r_out_valid)
        else $error("last byte processed without a result");

    // A last byte is held while the output register is full and stalled.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && r_out_valid && !m_axis_tready)
            |-> (!step_fire && !s_axis_tready))
        else $error("pending result would be overwritten");

    // A stalled result keeps its value.
    a_result_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled result changed");

endmodule

/* hdl/acp_classify.sv */
// ----------------------------------------------------------------------------
// acp_classify
// Decodes one byte into the character classes and digit value the parser uses.
// ----------------------------------------------------------------------------
module acp_classify (
    input  logic [acp_pkg::CHAR_W-1:0] i_char,
    output acp_pkg::t_char_class       o_class
);

    logic is_dec;
    logic is_lower_hex;
    logic is_upper_hex;

    assign is_dec       = (i_char >= acp_pkg::CH_ZERO)    && (i_char <= acp_pkg::CH_NINE);
    assign is_lower_hex = (i_char >= acp_pkg::CH_LOWER_A) && (i_char <= acp_pkg::CH_LOWER_F);
    assign is_upper_hex = (i_char >= acp_pkg::CH_UPPER_A) && (i_char <= acp_pkg::CH_UPPER_F);

    always_comb begin
        o_class.blank    = (i_char <= acp_pkg::CH_BLANK_MAX);
        o_class.plus     = (i_char == acp_pkg::CH_PLUS);
        o_class.minus    = (i_char == acp_pkg::CH_MINUS);
        o_class.zero     = (i_char == acp_pkg::CH_ZERO);
        o_class.quote    = (i_char == acp_pkg::CH_QUOTE);
        o_class.x_letter = (i_char == acp_pkg::CH_LOWER_X) || (i_char == acp_pkg::CH_UPPER_X);
        o_class.dec_ok   = is_dec;
        o_class.hex_ok   = is_dec || is_lower_hex || is_upper_hex;
        // Valid for decimal digits and hex letters alike; ignored otherwise.
        if (is_dec) begin
            o_class.digit = i_char[acp_pkg::DIGIT_W-1:0];
        end else begin
            o_class.digit = i_char[acp_pkg::DIGIT_W-1:0] + acp_pkg::HEX_LETTER_OFFSET;
        end
    end

endmodule

/* hdl/acp_step.sv */
// ----------------------------------------------------------------------------
// acp_step
// Parse state machine: phase, sign and accumulator, advanced once per byte.
// ----------------------------------------------------------------------------
module acp_step (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  logic                              i_last,
    input  logic [acp_pkg::CHAR_W-1:0]        i_char,
    input  acp_pkg::t_char_class              i_class,
    output logic signed [acp_pkg::VALUE_W-1:0] o_value
);

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGNED,
        PH_ZERO,
        PH_HEX,
        PH_QUOTE,
        PH_DEC,
        PH_FROZEN
    } t_phase;

    t_phase                      r_phase, n_phase;
    logic                        r_neg, n_neg;
    logic [acp_pkg::VALUE_W-1:0] r_acc, n_acc;

    // The accumulator carries the signed value directly: once a minus sign is
    // taken every digit is subtracted, which equals negating at the end.
    logic [acp_pkg::VALUE_W-1:0] digit_ext;
    logic [acp_pkg::VALUE_W-1:0] digit_term;
    logic [acp_pkg::VALUE_W-1:0] char_ext;
    logic [acp_pkg::VALUE_W-1:0] char_term;
    logic [acp_pkg::VALUE_W-1:0] acc_x10;
    logic [acp_pkg::VALUE_W-1:0] acc_x16;

    assign digit_ext  = {{(acp_pkg::VALUE_W-acp_pkg::DIGIT_W){1'b0}}, i_class.digit};
    assign digit_term = r_neg ? ({acp_pkg::VALUE_W{1'b0}} - digit_ext) : digit_ext;
    assign char_ext   = {{(acp_pkg::VALUE_W-acp_pkg::CHAR_W){1'b0}}, i_char};
    assign char_term  = r_neg ? ({acp_pkg::VALUE_W{1'b0}} - char_ext) : char_ext;
    assign acc_x10    = (r_acc << 3) + (r_acc << 1);
    assign acc_x16    = r_acc << 4;

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        case (r_phase)
            PH_SKIP, PH_SIGNED: begin
                if ((r_phase == PH_SKIP) && i_class.blank) begin
                    n_phase = PH_SKIP;
                end else if ((r_phase == PH_SKIP) && i_class.minus) begin
                    n_neg   = 1'b1;
                    n_phase = PH_SIGNED;
                end else if ((r_phase == PH_SKIP) && i_class.plus) begin
                    n_phase = PH_SIGNED;
                end else begin
                    // First byte of the body.
                    n_acc = '0;
                    if (i_class.zero) begin
                        n_phase = PH_ZERO;
                    end else if (i_class.quote) begin
                        n_phase = PH_QUOTE;
                    end else if (i_class.dec_ok) begin
                        n_acc   = digit_term;
                        n_phase = PH_DEC;
                    end else begin
                        n_phase = PH_FROZEN;
                    end
                end
            end
            PH_ZERO, PH_DEC: begin
                if ((r_phase == PH_ZERO) && i_class.x_letter) begin
                    n_acc   = '0;
                    n_phase = PH_HEX;
                end else if (i_class.dec_ok) begin
                    n_acc   = acc_x10 + digit_term;
                    n_phase = PH_DEC;
                end else begin
                    n_phase = PH_FROZEN;
                end
            end
            PH_HEX: begin
                if (i_class.hex_ok) begin
                    n_acc = acc_x16 + digit_term;
                end else begin
                    n_phase = PH_FROZEN;
                end
            end
            PH_QUOTE: begin
                n_acc   = char_term;
                n_phase = PH_FROZEN;
            end
            default: begin
                n_phase = PH_FROZEN;
            end
        endcase
    end

    assign o_value = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else if (i_fire) begin
            if (i_last) begin
                r_phase <= PH_SKIP;
                r_neg   <= 1'b0;
                r_acc   <= '0;
            end else begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
            end
        end
    end

endmodule
